// ===== hdl/rgbhsl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RGB888 to HSL converter.
// No dependencies; imported by every module of the block.
package rgbhsl_pkg;

    // Quotient bits produced by the divider chain, one per cell.
    localparam int unsigned QUOT_W = 8;
    // Dividends are {remainder, low bits}: twice the quotient width.
    localparam int unsigned ACC_W  = 2 * QUOT_W;

    localparam logic [9:0] HUE_FULL_TURN = 10'd360;

    typedef logic [7:0] t_chan;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_pixel;

    typedef struct packed {
        logic [8:0] hue_degrees;
        t_chan      saturation;
        t_chan      lightness;
    } t_hsl;

    // Which component is the maximum (red checked first, then green).
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    // Payload carried from stage to stage along the divider chain.
    typedef struct packed {
        logic [ACC_W-1:0]  sat_acc;   // {remainder, dividend / quotient bits}
        logic [QUOT_W-1:0] sat_den;
        logic [ACC_W-1:0]  hue_acc;
        logic [QUOT_W-1:0] hue_den;   // delta = max - min
        logic              hue_neg;   // sector offset below zero
        t_sector           sector;
        logic              grey;      // delta is zero
        t_chan             lightness;
    } t_cell_data;

    // Degrees at the start of each sector.
    function automatic logic [9:0] sector_base(input t_sector sec);
        logic [9:0] base;
        unique case (sec)
            SEC_RED:   base = 10'd0;
            SEC_GREEN: base = 10'd120;
            SEC_BLUE:  base = 10'd240;
            default:   base = 10'd0;
        endcase
        return base;
    endfunction

endpackage

// ===== hdl/rgbhsl_front.sv =====
`timescale 1ns / 1ps
// Entry stage: max/min, sector pick, delta, lightness and both dividends.
// Depends on rgbhsl_pkg.
module rgbhsl_front
    import rgbhsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_pixel     i_pixel,
    output logic       o_stall,
    output logic       o_valid,
    output t_cell_data o_data,
    input  logic       i_stall
);

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;
    logic       load;

    t_chan       mx, mn, delta, abs_off;
    logic [8:0]  sum;
    logic [8:0]  off;     // two's complement, -255..255
    logic [8:0]  den9;
    t_sector     sec;

    assign o_stall = r_valid && i_stall;
    assign load    = !o_stall;

    always_comb begin
        if (i_pixel.red >= i_pixel.green && i_pixel.red >= i_pixel.blue) begin
            sec = SEC_RED;
            mx  = i_pixel.red;
            off = {1'b0, i_pixel.green} - {1'b0, i_pixel.blue};
        end else if (i_pixel.green >= i_pixel.blue) begin
            sec = SEC_GREEN;
            mx  = i_pixel.green;
            off = {1'b0, i_pixel.blue} - {1'b0, i_pixel.red};
        end else begin
            sec = SEC_BLUE;
            mx  = i_pixel.blue;
            off = {1'b0, i_pixel.red} - {1'b0, i_pixel.green};
        end

        mn = i_pixel.red;
        if (i_pixel.green < mn) mn = i_pixel.green;
        if (i_pixel.blue < mn)  mn = i_pixel.blue;

        delta   = mx - mn;
        sum     = {1'b0, mx} + {1'b0, mn};
        // 255 - |sum - 255|
        den9    = (sum <= 9'd255) ? sum : (9'd510 - sum);
        abs_off = off[8] ? t_chan'(9'd0 - off) : off[7:0];

        n_data.sat_acc   = {delta, 8'd0} - {8'd0, delta};            // 255 * delta
        n_data.sat_den   = den9[7:0];
        n_data.hue_acc   = {2'd0, abs_off, 6'd0} - {6'd0, abs_off, 2'd0}; // 60 * |off|
        n_data.hue_den   = delta;
        n_data.hue_neg   = off[8];
        n_data.sector    = sec;
        n_data.grey      = (delta == 8'd0);
        n_data.lightness = sum[8:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/rgbhsl_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring-division cell: one quotient bit for saturation and for hue.
// Depends on rgbhsl_pkg.
module rgbhsl_div_cell
    import rgbhsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cell_data i_data,
    output logic       o_stall,
    output logic       o_valid,
    output t_cell_data o_data,
    input  logic       i_stall
);

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;
    logic       load;

    // Shift in the next dividend bit, trial-subtract, shift in the quotient bit.
    function automatic logic [ACC_W-1:0] div_step(
        input logic [ACC_W-1:0]  acc,
        input logic [QUOT_W-1:0] den
    );
        logic [QUOT_W:0] part;
        logic [QUOT_W:0] diff;
        logic            qbit;
        part = acc[ACC_W-1:QUOT_W-1];
        diff = part - {1'b0, den};
        qbit = (part >= {1'b0, den});
        if (qbit) part = diff;
        return {part[QUOT_W-1:0], acc[QUOT_W-2:0], qbit};
    endfunction

    assign o_stall = r_valid && i_stall;
    assign load    = !o_stall;

    always_comb begin
        n_data         = i_data;
        n_data.sat_acc = div_step(i_data.sat_acc, i_data.sat_den);
        n_data.hue_acc = div_step(i_data.hue_acc, i_data.hue_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/rgbhsl_back.sv =====
`timescale 1ns / 1ps
// Output stage: floors the signed sector offset, adds the sector base, wraps.
// Depends on rgbhsl_pkg.
module rgbhsl_back
    import rgbhsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cell_data i_data,
    output logic       o_stall,
    output logic       o_valid,
    output t_hsl       o_result,
    input  logic       i_stall
);

    logic       r_valid;
    t_hsl       r_result;
    t_hsl       n_result;
    logic       load;

    logic [QUOT_W-1:0] quot;
    logic              rem_nz;
    logic [9:0]        mag;
    logic [9:0]        hue;

    assign o_stall = r_valid && i_stall;
    assign load    = !o_stall;

    always_comb begin
        quot   = i_data.hue_acc[QUOT_W-1:0];
        rem_nz = |i_data.hue_acc[ACC_W-1:QUOT_W];
        // floor of a negative quotient rounds away from zero on a remainder
        mag    = i_data.hue_neg ? 10'(quot) + 10'(rem_nz) : 10'(quot);
        hue    = i_data.hue_neg ? sector_base(i_data.sector) - mag
                                : sector_base(i_data.sector) + mag;
        if (hue[9]) hue = hue + HUE_FULL_TURN;

        n_result.hue_degrees = i_data.grey ? 9'd0 : hue[8:0];
        n_result.saturation  = i_data.grey ? 8'd0 : i_data.sat_acc[QUOT_W-1:0];
        n_result.lightness   = i_data.lightness;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hdl/rgb_to_hsl_converter_top.sv =====
`timescale 1ns / 1ps
// RGB888 to HSL converter, top level: front stage, divider cell chain, output stage.
// Depends on rgbhsl_pkg, rgbhsl_front, rgbhsl_div_cell, rgbhsl_back.
//
//  port group        dir  request type  handshake
//  ----------------  ---  ------------  -------------------------------------
//  pixel in          in   t_pixel       i_valid / o_stall, taken if !o_stall
//  hsl out           out  t_hsl         o_valid / i_stall, taken if !i_stall
//
// Throughput is one request per clock while the output is not stalled. The pipe is
// one entry stage, one cell per quotient bit (QUOT_W = 8) and one output register.
// Every stage holds one request and loads whenever it is empty or its
// successor moves, so bubbles close up and the pipe keeps filling while a
// finished result is stalled. o_stall rises only when all stages are full
// and the output is stalled. Reset is synchronous and clears the valid bits
// only; the data registers are not reset.
module rgb_to_hsl_converter_top
    import rgbhsl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    // pixel in
    input  logic   i_valid,
    input  t_pixel i_pixel,
    output logic   o_stall,
    // hsl out
    output logic   o_valid,
    output t_hsl   o_result,
    input  logic   i_stall
);

    // Link k sits between stage k and stage k+1 of the chain.
    t_cell_data link_data  [0:QUOT_W];
    logic       link_valid [0:QUOT_W];
    logic       link_stall [0:QUOT_W];

    // Front: sector decode, delta, lightness, dividends 255*delta and 60*|offset|.
    rgbhsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_pixel (i_pixel),
        .o_stall (o_stall),
        .o_valid (link_valid[0]),
        .o_data  (link_data[0]),
        .i_stall (link_stall[0])
    );

    // Divider chain: each cell retires one quotient bit of both divisions,
    // most significant bit first.
    for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
        rgbhsl_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[k]),
            .i_data  (link_data[k]),
            .o_stall (link_stall[k]),
            .o_valid (link_valid[k+1]),
            .o_data  (link_data[k+1]),
            .i_stall (link_stall[k+1])
        );
    end

    // Output register: hue floor and wrap, grey pixel override.
    rgbhsl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (link_valid[QUOT_W]),
        .i_data   (link_data[QUOT_W]),
        .o_stall  (link_stall[QUOT_W]),
        .o_valid  (o_valid),
        .o_result (o_result),
        .i_stall  (i_stall)
    );

endmodule

// ===== hdl/rgbhsl_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the RGB888 to HSL converter, bound to the top level.
// Depends on rgbhsl_pkg and rgb_to_hsl_converter_top.
module rgbhsl_checker
    import rgbhsl_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_valid,
    input t_pixel i_pixel,
    input logic   o_stall,
    input logic   o_valid,
    input t_hsl   o_result,
    input logic   i_stall
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("stalled result changed");

    // Input backs up only when the output is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");

    // Hue stays inside one turn.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.hue_degrees < 9'd360)
        else $error("hue out of range");

    // Zero saturation only for grey pixels, whose hue is zero.
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.saturation == 8'd0 |-> o_result.hue_degrees == 9'd0)
        else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsl_converter_top rgbhsl_checker u_rgbhsl_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .i_pixel  (i_pixel),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .o_result (o_result),
    .i_stall  (i_stall)
);
